// ===== design/md5bh_pkg.sv =====
// Shared types, constants and round tables for the MD5 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package md5bh_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [2:0] TOP_MASK  = 3'h7;
   localparam int         PALETTE_SIZE = 8;

   localparam logic [5:0] FILL_LEN_START = 6'd56;
   localparam logic [5:0] FILL_LAST      = 6'd63;
   localparam logic [5:0] ROUND_LAST     = 6'd63;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } chain_type;

   typedef struct packed {
      logic [31:0] digest_word_a;
      logic [31:0] digest_word_b;
      logic [31:0] digest_word_c;
      logic [31:0] digest_word_d;
      logic [2:0]  palette_index;
   } result_type;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_PAD      = 6'b000010,
      ST_PREFETCH = 6'b000100,
      ST_ROUND    = 6'b001000,
      ST_ADD      = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate amount: depends on the round group and the low two bits.
   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0:    s = 5'd7;
         4'd1:    s = 5'd12;
         4'd2:    s = 5'd17;
         4'd3:    s = 5'd22;
         4'd4:    s = 5'd5;
         4'd5:    s = 5'd9;
         4'd6:    s = 5'd14;
         4'd7:    s = 5'd20;
         4'd8:    s = 5'd4;
         4'd9:    s = 5'd11;
         4'd10:   s = 5'd16;
         4'd11:   s = 5'd23;
         4'd12:   s = 5'd6;
         4'd13:   s = 5'd10;
         4'd14:   s = 5'd15;
         4'd15:   s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word used by a round (all arithmetic mod 16).
   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] r4;
      logic [3:0] idx;
      r4 = r[3:0];
      case (r[5:4])
         2'd0:    idx = r4;
         2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
         2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
         2'd3:    idx = 4'(r4 * 4'd7);
         default: idx = r4;
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== design/md5bh_if.sv =====
// Valid/ready channel interfaces for hasher requests and digest responses.
`timescale 1ns / 1ps
`default_nettype none

interface md5bh_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       last_item;

   modport source (output valid, output has_byte, output data_byte, output last_item,
                   input ready);
   modport sink   (input valid, input has_byte, input data_byte, input last_item,
                   output ready);
endinterface

interface md5bh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_a;
   logic [31:0] digest_word_b;
   logic [31:0] digest_word_c;
   logic [31:0] digest_word_d;
   logic [2:0]  palette_index;

   modport source (output valid, output digest_word_a, output digest_word_b,
                   output digest_word_c, output digest_word_d, output palette_index,
                   input ready);
   modport sink   (input valid, input digest_word_a, input digest_word_b,
                   input digest_word_c, input digest_word_d, input palette_index,
                   output ready);
endinterface

`default_nettype wire

// ===== design/md5_byte_stream_hasher_top.sv =====
// MD5 byte stream hasher top level: block buffer, padding sequencer, round loop.
// A byte that does not fill a block leaves the sequencer idle, so req ready stays high.
// A full block runs busy through one buffer prefetch, 64 rounds and one chain add.
// A last item adds a pad step per pad byte and a block run per block closed, then loads rsp once it is free.
// The digest stays in the rsp register while the next message streams in.
// Synchronous active-high reset: chain words to the MD5 initial values, counts to zero.
`timescale 1ns / 1ps
`default_nettype none

module md5_byte_stream_hasher_top (
   input  logic               clock,
   input  logic               reset,
   md5bh_req_if.sink          req_chan,
   md5bh_rsp_if.source        rsp_chan
);

   // ---------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------
   md5bh_pkg::state_type  state_ff, state_in;
   logic [5:0]            fill_ff, fill_in;        // bytes held in the block buffer
   logic [60:0]           len_ff, len_in;          // message bytes, wraps mod 2^61
   logic [5:0]            round_ff, round_in;
   md5bh_pkg::chain_type  chain_ff, chain_in;
   md5bh_pkg::chain_type  work_ff, work_in;
   md5bh_pkg::chain_type  round_out;
   logic                  pad_active_ff, pad_active_in;  // message closing
   logic                  pad_first_ff, pad_first_in;    // next pad byte is 0x80
   logic                  len_phase_ff, len_phase_in;    // writing the bit length
   logic                  rsp_valid_ff, rsp_valid_in;
   md5bh_pkg::result_type rsp_data_ff, rsp_data_in;

   // block buffer: 16 little-endian words, written a byte lane at a time
   logic [31:0]           buf_mem_ff [16];
   logic [31:0]           msg_word_ff;

   logic                  accept;
   logic                  out_free;
   logic                  pad_len;
   logic [63:0]           len_bits;
   logic [7:0]            pad_byte;
   logic                  wr_en;
   logic [7:0]            wr_byte;
   logic                  rd_en;
   logic [5:0]            rd_round;
   logic [3:0]            pal_calc;
   logic [2:0]            top_bits;

   assign req_chan.ready = (state_ff == md5bh_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // ---------------------------------------------------------------
   // Padding byte: 0x80, zeros up to offset 56, then the bit length
   // ---------------------------------------------------------------
   assign len_bits = {len_ff, 3'b000};
   assign pad_len  = !pad_first_ff && (len_phase_ff || fill_ff == md5bh_pkg::FILL_LEN_START);

   always_comb begin
      if (pad_first_ff) begin
         pad_byte = md5bh_pkg::PAD_BYTE;
      end else if (pad_len) begin
         pad_byte = len_bits[{fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   assign wr_en   = (accept && req_chan.has_byte) || (state_ff == md5bh_pkg::ST_PAD);
   assign wr_byte = (state_ff == md5bh_pkg::ST_PAD) ? pad_byte : req_chan.data_byte;

   // read one round ahead so the word is registered when the round runs
   assign rd_en    = (state_ff == md5bh_pkg::ST_PREFETCH) || (state_ff == md5bh_pkg::ST_ROUND);
   assign rd_round = (state_ff == md5bh_pkg::ST_PREFETCH) ? round_ff : 6'(round_ff + 6'd1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end
      if (rd_en) begin
         msg_word_ff <= buf_mem_ff[md5bh_pkg::msg_index(rd_round)];
      end
   end

   // ---------------------------------------------------------------
   // Shared round unit
   // ---------------------------------------------------------------
   md5bh_round u_round (
      .work_i     (work_ff),
      .round_i    (round_ff),
      .msg_word_i (msg_word_ff),
      .work_o     (round_out)
   );

   // palette index: low three bits of the top byte of D, reduced mod the palette size
   assign top_bits = chain_ff.d[26:24] & md5bh_pkg::TOP_MASK;

   always_comb begin
      pal_calc = {1'b0, top_bits};
      for (int i = 0; i < 8; i++) begin
         if (pal_calc >= 4'(md5bh_pkg::PALETTE_SIZE)) begin
            pal_calc = pal_calc - 4'(md5bh_pkg::PALETTE_SIZE);
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      round_in      = round_ff;
      chain_in      = chain_ff;
      work_in       = work_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      len_phase_in  = len_phase_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         md5bh_pkg::ST_IDLE: begin
            if (accept) begin
               pad_active_in = req_chan.last_item;
               pad_first_in  = req_chan.last_item;
               if (req_chan.has_byte) begin
                  fill_in = 6'(fill_ff + 6'd1);
                  len_in  = 61'(len_ff + 61'd1);
               end
               if (req_chan.has_byte && fill_ff == md5bh_pkg::FILL_LAST) begin
                  round_in = 6'd0;
                  state_in = md5bh_pkg::ST_PREFETCH;
               end else if (req_chan.last_item) begin
                  state_in = md5bh_pkg::ST_PAD;
               end
            end
         end
         md5bh_pkg::ST_PAD: begin
            fill_in      = 6'(fill_ff + 6'd1);
            pad_first_in = 1'b0;
            if (pad_len) begin
               len_phase_in = 1'b1;
            end
            if (fill_ff == md5bh_pkg::FILL_LAST) begin
               round_in = 6'd0;
               state_in = md5bh_pkg::ST_PREFETCH;
            end
         end
         md5bh_pkg::ST_PREFETCH: begin
            work_in  = chain_ff;
            state_in = md5bh_pkg::ST_ROUND;
         end
         md5bh_pkg::ST_ROUND: begin
            work_in  = round_out;
            round_in = 6'(round_ff + 6'd1);
            if (round_ff == md5bh_pkg::ROUND_LAST) begin
               state_in = md5bh_pkg::ST_ADD;
            end
         end
         md5bh_pkg::ST_ADD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            if (len_phase_ff) begin
               state_in = md5bh_pkg::ST_DONE;
            end else if (pad_active_ff) begin
               state_in = md5bh_pkg::ST_PAD;
            end else begin
               state_in = md5bh_pkg::ST_IDLE;
            end
         end
         md5bh_pkg::ST_DONE: begin
            // hold until the rsp register is free, then restart the message
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.digest_word_a = chain_ff.a;
               rsp_data_in.digest_word_b = chain_ff.b;
               rsp_data_in.digest_word_c = chain_ff.c;
               rsp_data_in.digest_word_d = chain_ff.d;
               rsp_data_in.palette_index = pal_calc[2:0];
               chain_in      = '{a: md5bh_pkg::INIT_A, b: md5bh_pkg::INIT_B,
                                 c: md5bh_pkg::INIT_C, d: md5bh_pkg::INIT_D};
               fill_in       = 6'd0;
               len_in        = '0;
               pad_active_in = 1'b0;
               pad_first_in  = 1'b0;
               len_phase_in  = 1'b0;
               state_in      = md5bh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = md5bh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= md5bh_pkg::ST_IDLE;
         fill_ff       <= 6'd0;
         len_ff        <= '0;
         round_ff      <= 6'd0;
         chain_ff      <= '{a: md5bh_pkg::INIT_A, b: md5bh_pkg::INIT_B,
                            c: md5bh_pkg::INIT_C, d: md5bh_pkg::INIT_D};
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         len_phase_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         len_ff        <= len_in;
         round_ff      <= round_in;
         chain_ff      <= chain_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         len_phase_ff  <= len_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.digest_word_a = rsp_data_ff.digest_word_a;
   assign rsp_chan.digest_word_b = rsp_data_ff.digest_word_b;
   assign rsp_chan.digest_word_c = rsp_data_ff.digest_word_c;
   assign rsp_chan.digest_word_d = rsp_data_ff.digest_word_d;
   assign rsp_chan.palette_index = rsp_data_ff.palette_index;

endmodule

`default_nettype wire

// ===== design/md5bh_round.sv =====
// One MD5 round: boolean function, four-operand add, rotate and final add.
`timescale 1ns / 1ps
`default_nettype none

module md5bh_round (
   input  md5bh_pkg::chain_type work_i,
   input  logic [5:0]           round_i,
   input  logic [31:0]          msg_word_i,
   output md5bh_pkg::chain_type work_o
);

   logic [31:0] f;
   logic [31:0] sum;
   logic [63:0] rot_wide;
   logic [31:0] rot;

   always_comb begin
      case (round_i[5:4])
         2'd0:    f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
         2'd1:    f = (work_i.d & work_i.b) | (~work_i.d & work_i.c);
         2'd2:    f = work_i.b ^ work_i.c ^ work_i.d;
         2'd3:    f = work_i.c ^ (work_i.b | ~work_i.d);
         default: f = work_i.b ^ work_i.c ^ work_i.d;
      endcase
   end

   assign sum      = work_i.a + f + md5bh_pkg::ROUND_K[round_i] + msg_word_i;
   // rotate: the upper half of the doubled word shifted left
   assign rot_wide = {sum, sum} << md5bh_pkg::rot_amount(round_i);
   assign rot      = rot_wide[63:32];

   assign work_o.a = work_i.d;
   assign work_o.b = work_i.b + rot;
   assign work_o.c = work_i.b;
   assign work_o.d = work_i.c;

endmodule

`default_nettype wire

// ===== design/md5bh_checker.sv =====
// Port-level checker for the hasher top level and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module md5bh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_item,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word_a,
   input logic [31:0] rsp_digest_word_d,
   input logic [2:0]  rsp_palette_index
);

   // no result straight out of reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a closing transfer always leaves idle for padding or a block run, so the block goes busy
   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_item) |=> !req_ready)
      else $error("ready after last transfer");

   // a new digest only comes out of the busy finishing phase
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("digest without finishing phase");

   // stalled digest holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_digest_word_a) && $stable(rsp_digest_word_d)))
      else $error("stalled digest changed");

   a_palette_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_palette_index} < 4'(md5bh_pkg::PALETTE_SIZE)))
      else $error("palette index out of range");

endmodule

bind md5_byte_stream_hasher_top md5bh_checker u_md5bh_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_last_item     (req_chan.last_item),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_digest_word_a (rsp_chan.digest_word_a),
   .rsp_digest_word_d (rsp_chan.digest_word_d),
   .rsp_palette_index (rsp_chan.palette_index)
);

`default_nettype wire
